/* hw/rtl/swmm_pkg.sv */
// Shared widths and types for the sliding window minimum and maximum block.
`default_nettype none
package swmm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int DEPTH    = 64;
  localparam int AGE_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);

  localparam logic [CNT_W-1:0] WIN_RESET = CNT_W'(3);
  localparam logic [CNT_W-1:0] WIN_MAX   = CNT_W'(DEPTH);

  // One queue slot as seen by its neighbor.
  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] value;
    logic [AGE_W-1:0]           age;
  } slot_t;

  // Control shared by every cell of a queue.
  typedef struct packed {
    logic                       step;
    logic                       clear;
    logic                       evict;
    logic                       want_min;
    logic signed [SAMPLE_W-1:0] sample;
  } cell_ctl_t;

endpackage
`default_nettype wire

/* hw/rtl/swmm_cell.sv */
// One slot of a monotonic queue: holds a candidate and its age.
`default_nettype none
module swmm_cell
  import swmm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cell_ctl_t ctl,
  input  wire slot_t     up,
  input  wire logic      prev_keep,
  output slot_t          slot,
  output slot_t          slot_next,
  output logic           keep
);

  slot_t sh;
  logic  place;
  logic  drop;

  always_comb begin
    sh = ctl.evict ? up : slot;
    drop = ctl.want_min ? (ctl.sample < sh.value) : (ctl.sample > sh.value);
    keep = sh.valid && !drop;
    place = !keep && prev_keep;
    slot_next = slot;
    if (ctl.step) begin
      slot_next.valid = keep || place;
      slot_next.value = keep ? sh.value : ctl.sample;
      slot_next.age   = keep ? sh.age + AGE_W'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    slot.value <= slot_next.value;
    slot.age   <= slot_next.age;
    if (rst || ctl.clear) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= slot_next.valid;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/swmm_deque.sv */
// Row of cells forming one monotonic queue, head in cell zero.
`default_nettype none
module swmm_deque
  import swmm_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step,
  input  wire logic                       clear,
  input  wire logic                       want_min,
  input  wire logic [AGE_W-1:0]           age_limit,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  output logic signed [SAMPLE_W-1:0]      head_next
);

  slot_t     slots [DEPTH];
  slot_t     nexts [DEPTH];
  slot_t     ups   [DEPTH];
  logic      keeps [DEPTH];
  logic      prevs [DEPTH];
  cell_ctl_t ctl;

  // The head leaves when it is the sample falling out of the window.
  always_comb begin
    ctl.step     = step;
    ctl.clear    = clear;
    ctl.want_min = want_min;
    ctl.sample   = sample;
    ctl.evict    = step && slots[0].valid && (slots[0].age == age_limit);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_last
      assign ups[i] = '0;
    end else begin : g_mid
      assign ups[i] = slots[i+1];
    end
    if (i == 0) begin : g_first
      assign prevs[i] = 1'b1;
    end else begin : g_rest
      assign prevs[i] = keeps[i-1];
    end
    swmm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .up        (ups[i]),
      .prev_keep (prevs[i]),
      .slot      (slots[i]),
      .slot_next (nexts[i]),
      .keep      (keeps[i])
    );
  end

  assign head_next = nexts[0].value;

endmodule
`default_nettype wire

/* hw/rtl/sliding_window_min_max.sv */
// Sliding window minimum and maximum over a stream of signed samples.
// A result is registered and appears on the master side in the cycle after its sample is taken.
// Throughput: one sample per cycle while the master side keeps up; each sample updates both queue rows in that cycle.
// The slave side stalls only while a result waits that the master side does not take.
// Reset (synchronous, active high) empties both queues, clears the fill count and
// sets the window to three samples; a window_size write restarts the stream likewise.
`default_nettype none
module sliding_window_min_max
  import swmm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CNT_W-1:0]      cfg_wdata,     // window_size
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [SAMPLE_W-1:0]   s_tdata,       // sample
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [2*SAMPLE_W-1:0]      m_tdata        // window_max (upper half), window_min (lower half)
);

  logic [CNT_W-1:0]            window_size;
  logic [CNT_W-1:0]            win;
  logic [CNT_W-1:0]            fill_count;
  logic [CNT_W-1:0]            fill_count_next;
  logic [AGE_W-1:0]            age_limit;
  logic                        accept;
  logic signed [SAMPLE_W-1:0]  sample;
  logic signed [SAMPLE_W-1:0]  min_head;
  logic signed [SAMPLE_W-1:0]  max_head;

  // A zero window acts as one sample, anything beyond the row length as the full row.
  always_comb begin
    if (window_size == '0) begin
      win = CNT_W'(1);
    end else if (window_size > WIN_MAX) begin
      win = WIN_MAX;
    end else begin
      win = window_size;
    end
    // An entry leaves once it has aged through win - 1 later samples.
    age_limit = AGE_W'(win - CNT_W'(1));
    fill_count_next = (fill_count < win) ? fill_count + CNT_W'(1) : fill_count;
  end

  // The output register parts the two sides, so a new sample is taken whenever no result
  // is pending or the pending result is being taken in the same cycle.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign sample   = s_tdata;

  swmm_deque u_min (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .clear     (cfg_we),
    .want_min  (1'b1),
    .age_limit (age_limit),
    .sample    (sample),
    .head_next (min_head)
  );

  swmm_deque u_max (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .clear     (cfg_we),
    .want_min  (1'b0),
    .age_limit (age_limit),
    .sample    (sample),
    .head_next (max_head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WIN_RESET;
      fill_count  <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_size <= cfg_wdata;
        fill_count  <= '0;
      end else if (accept) begin
        fill_count <= fill_count_next;
      end
      // A result leaves only once the window has filled.
      if (accept && !cfg_we && (fill_count_next >= win)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {max_head, min_head};
    end
  end

endmodule
`default_nettype wire
